### hw/rtl/mpbs_pkg.sv
// ----------------------------------------------------------------------------
// mpbs_pkg
// Types and constants shared by the multi-pattern byte scanner.
// ----------------------------------------------------------------------------
package mpbs_pkg;

   localparam int NODES      = 256;
   localparam int ALPHABET   = 128;
   localparam int PATTERNS   = 16;
   localparam int MAXREPORTS = 16;

   localparam int NODE_W  = $clog2(NODES);
   localparam int SYM_W   = $clog2(ALPHABET);
   localparam int PAT_W   = $clog2(PATTERNS);
   localparam int GOTO_AW = NODE_W + SYM_W;

   typedef enum logic [1:0] {
      CMD_WR_INFO = 2'd0,
      CMD_WR_GOTO = 2'd1,
      CMD_SCAN    = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [4:0] len;
      logic [3:0] id;
      logic       ends;
      logic [7:0] olink;
      logic       olv;
      logic [7:0] fail;
   } info_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] target;
   } goto_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GOTO,
      ST_GCHK,
      ST_FAIL,
      ST_INFO,
      ST_ICHK,
      ST_FLUSH
   } state_type;

endpackage

### hw/rtl/mpbs_if.sv
// ----------------------------------------------------------------------------
// mpbs channel interfaces
// Valid/ready channels for scanner commands and match reports.
// ----------------------------------------------------------------------------
interface mpbs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] node;
   logic [7:0] symbol;
   logic       goto_valid;
   logic [7:0] goto_target;
   logic [7:0] fail_state;
   logic       out_link_valid;
   logic [7:0] out_link;
   logic       ends_pattern;
   logic [3:0] pattern_id;
   logic [4:0] pattern_len;

   modport source (output valid, cmd, node, symbol, goto_valid, goto_target, fail_state,
                   out_link_valid, out_link, ends_pattern, pattern_id, pattern_len,
                   input ready);
   modport sink (input valid, cmd, node, symbol, goto_valid, goto_target, fail_state,
                 out_link_valid, out_link, ends_pattern, pattern_id, pattern_len,
                 output ready);
endinterface

interface mpbs_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  match_id;
   logic [31:0] start_offset;
   logic [31:0] hit_count;
   logic        last;

   modport source (output valid, match_id, start_offset, hit_count, last, input ready);
   modport sink (input valid, match_id, start_offset, hit_count, last, output ready);
endinterface

### hw/rtl/multi_pattern_byte_scanner_unit.sv
// ----------------------------------------------------------------------------
// multi_pattern_byte_scanner_unit
// Aho-Corasick scanner: goto/fail walk and output-link chain over two RAMs.
// ----------------------------------------------------------------------------
//  channel | dir | carries
//  req     | in  | table writes, text bytes, restart
//  rsp     | out | one match report per word, last marks end of byte
//
//  table writes, restart and out-of-alphabet bytes complete on accept, leaving the unit idle
//  a scan byte is accepted, then steps through ST_GOTO and ST_GCHK per goto read, ST_FAIL
//  per fail move (each fail move is followed by another goto read), ST_INFO for the first
//  info read, ST_ICHK per chain state and ST_FLUSH; RAM reads are registered
//  reset clears the walk state, text offset and all hit counters; tables are not cleared
//  a stalled rsp holds the walk at the next report
module multi_pattern_byte_scanner_unit (
   input  logic clock,
   input  logic reset,
   mpbs_req_if.sink   req,
   mpbs_rsp_if.source rsp
);
   localparam int NW = mpbs_pkg::NODE_W;

   mpbs_pkg::state_type state_ff, state_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic [mpbs_pkg::SYM_W-1:0] sym_ff, sym_in;
   logic [NW:0]   steps_ff, steps_in;
   logic [NW:0]   visits_ff, visits_in;
   logic [4:0]    n_ff, n_in;
   logic [31:0]   offset_ff, offset_in;

   logic          pend_ff, pend_in;
   logic [3:0]    pend_id_ff, pend_id_in;
   logic [31:0]   pend_off_ff, pend_off_in;
   logic [31:0]   pend_hc_ff, pend_hc_in;

   logic          rv_ff, rv_in;
   logic [3:0]    rid_ff, rid_in;
   logic [31:0]   roff_ff, roff_in;
   logic [31:0]   rhc_ff, rhc_in;
   logic          rlast_ff, rlast_in;

   logic goto_we, goto_re, info_we, info_re;
   logic [mpbs_pkg::GOTO_AW-1:0] goto_waddr;
   mpbs_pkg::goto_type goto_wdata, goto_rdata;
   mpbs_pkg::info_type info_wdata, info_rdata;
   logic [NW-1:0] info_raddr;

   logic        cnt_inc;
   logic [31:0] cnt_new;

   logic accept, slot_free, hit, brk;

   assign accept    = req.valid && req.ready;
   assign slot_free = !rv_ff || rsp.ready;
   assign req.ready = (state_ff == mpbs_pkg::ST_IDLE);

   assign goto_waddr = {req.node[NW-1:0], req.symbol[mpbs_pkg::SYM_W-1:0]};
   assign goto_wdata = '{valid: req.goto_valid, target: req.goto_target};
   assign info_wdata = '{len: req.pattern_len, id: req.pattern_id, ends: req.ends_pattern,
                         olink: req.out_link, olv: req.out_link_valid,
                         fail: req.fail_state};

   mpbs_ram #(.WIDTH($bits(mpbs_pkg::goto_type)), .DEPTH(mpbs_pkg::NODES * mpbs_pkg::ALPHABET))
   u_goto (
      .clock  (clock),
      .wr_en  (goto_we),
      .wr_addr(goto_waddr),
      .wr_data(goto_wdata),
      .rd_en  (goto_re),
      .rd_addr({cur_ff, sym_ff}),
      .rd_data(goto_rdata)
   );

   mpbs_ram #(.WIDTH($bits(mpbs_pkg::info_type)), .DEPTH(mpbs_pkg::NODES)) u_info (
      .clock  (clock),
      .wr_en  (info_we),
      .wr_addr(req.node[NW-1:0]),
      .wr_data(info_wdata),
      .rd_en  (info_re),
      .rd_addr(info_raddr),
      .rd_data(info_rdata)
   );

   mpbs_counts u_counts (
      .clock    (clock),
      .reset    (reset),
      .inc      (cnt_inc),
      .id       (info_rdata.id),
      .count_new(cnt_new)
   );

   assign hit = info_rdata.ends && (n_ff < 5'(mpbs_pkg::MAXREPORTS));
   assign brk = !info_rdata.olv || (visits_ff + 1'b1 >= (NW+1)'(mpbs_pkg::NODES))
                || ((n_ff + 5'(hit)) >= 5'(mpbs_pkg::MAXREPORTS));

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      sym_in      = sym_ff;
      steps_in    = steps_ff;
      visits_in   = visits_ff;
      n_in        = n_ff;
      offset_in   = offset_ff;
      pend_in     = pend_ff;
      pend_id_in  = pend_id_ff;
      pend_off_in = pend_off_ff;
      pend_hc_in  = pend_hc_ff;
      rv_in       = rv_ff && !rsp.ready;
      rid_in      = rid_ff;
      roff_in     = roff_ff;
      rhc_in      = rhc_ff;
      rlast_in    = rlast_ff;
      goto_we     = 1'b0;
      goto_re     = 1'b0;
      info_we     = 1'b0;
      info_re     = 1'b0;
      info_raddr  = cur_ff;
      cnt_inc     = 1'b0;

      case (state_ff)
         mpbs_pkg::ST_IDLE: begin
            if (accept) begin
               case (mpbs_pkg::cmd_type'(req.cmd))
                  mpbs_pkg::CMD_WR_INFO: info_we = 1'b1;
                  mpbs_pkg::CMD_WR_GOTO: goto_we = (req.symbol < 8'(mpbs_pkg::ALPHABET));
                  mpbs_pkg::CMD_RESTART: begin
                     cur_in    = '0;
                     offset_in = '0;
                  end
                  default: begin
                     if (req.symbol < 8'(mpbs_pkg::ALPHABET)) begin
                        sym_in   = req.symbol[mpbs_pkg::SYM_W-1:0];
                        steps_in = '0;
                        state_in = mpbs_pkg::ST_GOTO;
                     end else begin
                        offset_in = offset_ff + 32'd1;
                     end
                  end
               endcase
            end
         end
         mpbs_pkg::ST_GOTO: begin
            goto_re  = 1'b1;
            state_in = mpbs_pkg::ST_GCHK;
         end
         mpbs_pkg::ST_GCHK: begin
            if (goto_rdata.valid || cur_ff == '0) begin
               if (goto_rdata.valid) begin
                  cur_in = goto_rdata.target[NW-1:0];
               end
               visits_in = '0;
               n_in      = '0;
               state_in  = mpbs_pkg::ST_INFO;
            end else if (steps_ff[NW]) begin
               // fail chain loops: fall to root
               cur_in   = '0;
               state_in = mpbs_pkg::ST_GOTO;
            end else begin
               info_re  = 1'b1;
               state_in = mpbs_pkg::ST_FAIL;
            end
         end
         mpbs_pkg::ST_FAIL: begin
            cur_in   = info_rdata.fail[NW-1:0];
            steps_in = steps_ff + 1'b1;
            state_in = mpbs_pkg::ST_GOTO;
         end
         mpbs_pkg::ST_INFO: begin
            // cur_ff holds the new state, its info starts the chain walk
            info_re    = 1'b1;
            info_raddr = cur_ff;
            state_in   = mpbs_pkg::ST_ICHK;
         end
         mpbs_pkg::ST_ICHK: begin
            if (!(hit && pend_ff && !slot_free)) begin
               if (hit) begin
                  if (pend_ff) begin
                     rv_in    = 1'b1;
                     rid_in   = pend_id_ff;
                     roff_in  = pend_off_ff;
                     rhc_in   = pend_hc_ff;
                     rlast_in = 1'b0;
                  end
                  cnt_inc     = 1'b1;
                  pend_in     = 1'b1;
                  pend_id_in  = info_rdata.id;
                  pend_off_in = offset_ff - 32'(info_rdata.len) + 32'd1;
                  pend_hc_in  = cnt_new;
                  n_in        = n_ff + 5'd1;
               end
               visits_in = visits_ff + 1'b1;
               if (brk) begin
                  state_in = mpbs_pkg::ST_FLUSH;
               end else begin
                  info_re    = 1'b1;
                  info_raddr = info_rdata.olink[NW-1:0];
                  state_in   = mpbs_pkg::ST_ICHK;
               end
            end
         end
         mpbs_pkg::ST_FLUSH: begin
            if (!pend_ff || slot_free) begin
               if (pend_ff) begin
                  rv_in    = 1'b1;
                  rid_in   = pend_id_ff;
                  roff_in  = pend_off_ff;
                  rhc_in   = pend_hc_ff;
                  rlast_in = 1'b1;
               end
               pend_in   = 1'b0;
               offset_in = offset_ff + 32'd1;
               state_in  = mpbs_pkg::ST_IDLE;
            end
         end
         default: state_in = mpbs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mpbs_pkg::ST_IDLE;
         cur_ff    <= '0;
         offset_ff <= '0;
         pend_ff   <= 1'b0;
         rv_ff     <= 1'b0;
         steps_ff  <= '0;
         visits_ff <= '0;
         n_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         cur_ff    <= cur_in;
         offset_ff <= offset_in;
         pend_ff   <= pend_in;
         rv_ff     <= rv_in;
         steps_ff  <= steps_in;
         visits_ff <= visits_in;
         n_ff      <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff      <= sym_in;
      pend_id_ff  <= pend_id_in;
      pend_off_ff <= pend_off_in;
      pend_hc_ff  <= pend_hc_in;
      rid_ff      <= rid_in;
      roff_ff     <= roff_in;
      rhc_ff      <= rhc_in;
      rlast_ff    <= rlast_in;
   end

   assign rsp.valid        = rv_ff;
   assign rsp.match_id     = rid_ff;
   assign rsp.start_offset = roff_ff;
   assign rsp.hit_count    = rhc_ff;
   assign rsp.last         = rlast_ff;
endmodule

### hw/rtl/mpbs_ram.sv
// ----------------------------------------------------------------------------
// mpbs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mpbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### hw/rtl/mpbs_counts.sv
// ----------------------------------------------------------------------------
// mpbs_counts
// Per-pattern saturating hit counters with a single shared incrementer.
// ----------------------------------------------------------------------------
module mpbs_counts (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      inc,
   input  logic [mpbs_pkg::PAT_W-1:0] id,
   output logic [31:0]               count_new
);
   logic [31:0] count_ff [mpbs_pkg::PATTERNS];
   logic [31:0] cur;

   assign cur       = count_ff[id];
   assign count_new = (cur == 32'hFFFF_FFFF) ? cur : cur + 32'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mpbs_pkg::PATTERNS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (inc) begin
         count_ff[id] <= count_new;
      end
   end
endmodule

### bench/tb_multi_pattern_byte_scanner_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_pattern_byte_scanner_unit
// Loads small random automata into the scanner, streams text bytes through
// them and checks every match report against a behavioral copy of the
// goto/fail walk and output-link chain kept in a scoreboard class.
// ----------------------------------------------------------------------------
module tb_multi_pattern_byte_scanner_unit;

   localparam int REPORT_CAP = 16;
   localparam int WATCHDOG   = 8000;
   localparam int DRAIN      = 1200;
   localparam int RAND_WORDS = 480;

   typedef struct {
      mpbs_pkg::cmd_type cmd;
      logic [7:0] node;
      logic [7:0] symbol;
      logic       goto_valid;
      logic [7:0] goto_target;
      logic [7:0] fail_state;
      logic       out_link_valid;
      logic [7:0] out_link;
      logic       ends_pattern;
      logic [3:0] pattern_id;
      logic [4:0] pattern_len;
   } scan_word_type;

   typedef struct {
      logic [3:0]  match_id;
      logic [31:0] start_offset;
      logic [31:0] hit_count;
      logic        last;
   } match_rpt_type;

   class match_tracker;
      logic [8:0]  goto_mem [mpbs_pkg::NODES*mpbs_pkg::ALPHABET];
      mpbs_pkg::info_type info_mem [mpbs_pkg::NODES];
      logic [7:0]  walk_state;
      logic [31:0] text_pos;
      logic [31:0] hits [mpbs_pkg::PATTERNS];
      match_rpt_type pending_reports [$];
      int          errors;

      function new();
         walk_state = '0;
         text_pos   = '0;
         errors     = 0;
         foreach (hits[i]) hits[i] = '0;
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      // walk one accepted word and queue the match reports it causes
      function void take_word(scan_word_type w);
         int         s;
         int         steps;
         int         visits;
         int         n;
         logic [8:0] e;
         mpbs_pkg::info_type inf;
         match_rpt_type r;
         case (w.cmd)
            mpbs_pkg::CMD_WR_INFO: begin
               inf.fail  = w.fail_state;
               inf.olv   = w.out_link_valid;
               inf.olink = w.out_link;
               inf.ends  = w.ends_pattern;
               inf.id    = w.pattern_id;
               inf.len   = w.pattern_len;
               info_mem[w.node] = inf;
            end
            mpbs_pkg::CMD_WR_GOTO: begin
               if (w.symbol < mpbs_pkg::ALPHABET)
                  goto_mem[int'(w.node) * mpbs_pkg::ALPHABET + int'(w.symbol)] =
                     {w.goto_valid, w.goto_target};
            end
            mpbs_pkg::CMD_RESTART: begin
               walk_state = '0;
               text_pos   = '0;
            end
            default: begin
               if (w.symbol < mpbs_pkg::ALPHABET) begin
                  s = int'(walk_state);
                  steps = 0;
                  while (1) begin
                     e = goto_mem[s * mpbs_pkg::ALPHABET + int'(w.symbol)];
                     if (e[8]) break;
                     if (s == 0) break;
                     if (steps >= mpbs_pkg::NODES) begin
                        s = 0;
                        continue;
                     end
                     s = int'(info_mem[s].fail);
                     steps++;
                  end
                  if (e[8]) s = int'(e[7:0]);
                  walk_state = 8'(s);
                  visits = 0;
                  n = 0;
                  while (1) begin
                     inf = info_mem[s];
                     if (inf.ends && n < REPORT_CAP) begin
                        if (hits[inf.id] != 32'hFFFF_FFFF) hits[inf.id]++;
                        r.match_id     = inf.id;
                        r.start_offset = text_pos - 32'(inf.len) + 32'd1;
                        r.hit_count    = hits[inf.id];
                        r.last         = 1'b0;
                        pending_reports.push_back(r);
                        n++;
                     end
                     visits++;
                     if (!inf.olv || visits >= mpbs_pkg::NODES || n >= REPORT_CAP) break;
                     s = int'(inf.olink);
                  end
                  if (n > 0) pending_reports[pending_reports.size()-1].last = 1'b1;
               end
               text_pos++;
            end
         endcase
      endfunction

      task check_report(match_rpt_type got);
         match_rpt_type want;
         if (pending_reports.size() == 0) begin
            report($sformatf("unexpected report id %0d", got.match_id));
         end else begin
            want = pending_reports.pop_front();
            if (got.match_id !== want.match_id)
               report($sformatf("match_id %0d, want %0d", got.match_id, want.match_id));
            if (got.start_offset !== want.start_offset)
               report($sformatf("start_offset %h, want %h",
                                got.start_offset, want.start_offset));
            if (got.hit_count !== want.hit_count)
               report($sformatf("hit_count %0d, want %0d", got.hit_count, want.hit_count));
            if (got.last !== want.last)
               report($sformatf("last %b, want %b", got.last, want.last));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   bit   calm;
   int   quiet_cycles;
   int   words_sent;
   match_tracker tracker;

   mpbs_req_if req_ch ();
   mpbs_rsp_if rsp_ch ();

   multi_pattern_byte_scanner_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // result side: check on accept, then pick next ready
   always @(posedge clock) begin
      match_rpt_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.match_id     = rsp_ch.match_id;
         got.start_offset = rsp_ch.start_offset;
         got.hit_count    = rsp_ch.hit_count;
         got.last         = rsp_ch.last;
         tracker.check_report(got);
      end
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= calm || ($urandom_range(99) >= 28);
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic scan_word_type rand_word(mpbs_pkg::cmd_type c);
      scan_word_type w;
      w.cmd            = c;
      w.node           = 8'($urandom);
      w.symbol         = 8'($urandom);
      w.goto_valid     = 1'($urandom);
      w.goto_target    = 8'($urandom);
      w.fail_state     = 8'($urandom);
      w.out_link_valid = 1'($urandom);
      w.out_link       = 8'($urandom);
      w.ends_pattern   = 1'($urandom);
      w.pattern_id     = 4'($urandom);
      w.pattern_len    = 5'($urandom_range(1, 16));
      return w;
   endfunction

   task push_word(scan_word_type w);
      while (!calm && $urandom_range(99) < 28) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.cmd            <= w.cmd;
      req_ch.node           <= w.node;
      req_ch.symbol         <= w.symbol;
      req_ch.goto_valid     <= w.goto_valid;
      req_ch.goto_target    <= w.goto_target;
      req_ch.fail_state     <= w.fail_state;
      req_ch.out_link_valid <= w.out_link_valid;
      req_ch.out_link       <= w.out_link;
      req_ch.ends_pattern   <= w.ends_pattern;
      req_ch.pattern_id     <= w.pattern_id;
      req_ch.pattern_len    <= w.pattern_len;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tracker.take_word(w);
      words_sent++;
   endtask

   task put_info(int nd, int fl, bit olv, int ol, bit ends, int id, int len);
      scan_word_type w;
      w = rand_word(mpbs_pkg::CMD_WR_INFO);
      w.node = 8'(nd); w.fail_state = 8'(fl); w.out_link_valid = olv; w.out_link = 8'(ol);
      w.ends_pattern = ends; w.pattern_id = 4'(id); w.pattern_len = 5'(len);
      push_word(w);
   endtask

   task put_goto(int nd, int sym, bit v, int tgt);
      scan_word_type w;
      w = rand_word(mpbs_pkg::CMD_WR_GOTO);
      w.node = 8'(nd); w.symbol = 8'(sym); w.goto_valid = v; w.goto_target = 8'(tgt);
      push_word(w);
   endtask

   task put_byte(int sym);
      scan_word_type w;
      w = rand_word(mpbs_pkg::CMD_SCAN);
      w.symbol = 8'(sym);
      push_word(w);
   endtask

   task wait_drained();
      while (tracker.pending_reports.size() != 0) @(posedge clock);
   endtask

   // random automaton over a few nodes and symbols, then text over it
   task run_phase();
      int nodes [$];
      int syms [$];
      int n;
      int k;
      int r;
      bit dup;
      scan_word_type w;
      n = $urandom_range(2, 8);
      k = $urandom_range(1, 4);
      nodes.push_back(0);
      while (nodes.size() < n) begin
         r = $urandom_range(1, 255);
         dup = 0;
         foreach (nodes[i]) if (nodes[i] == r) dup = 1;
         if (!dup) nodes.push_back(r);
      end
      while (syms.size() < k) begin
         r = $urandom_range(0, mpbs_pkg::ALPHABET - 1);
         dup = 0;
         foreach (syms[i]) if (syms[i] == r) dup = 1;
         if (!dup) syms.push_back(r);
      end
      foreach (nodes[i]) begin
         w = rand_word(mpbs_pkg::CMD_WR_INFO);
         w.node = 8'(nodes[i]);
         w.fail_state = 8'(nodes[$urandom_range(0, n - 1)]);
         if (w.out_link_valid) w.out_link = 8'(nodes[$urandom_range(0, n - 1)]);
         push_word(w);
      end
      foreach (nodes[i]) foreach (syms[j]) begin
         w = rand_word(mpbs_pkg::CMD_WR_GOTO);
         w.node = 8'(nodes[i]);
         w.symbol = 8'(syms[j]);
         w.goto_valid = $urandom_range(99) < 60;
         if (w.goto_valid) w.goto_target = 8'(nodes[$urandom_range(0, n - 1)]);
         push_word(w);
      end
      // write outside the alphabet, dropped by the block
      w = rand_word(mpbs_pkg::CMD_WR_GOTO);
      w.symbol = 8'($urandom_range(mpbs_pkg::ALPHABET, 255));
      push_word(w);
      push_word(rand_word(mpbs_pkg::CMD_RESTART));
      repeat ($urandom_range(20, 60)) begin
         r = $urandom_range(99);
         if (r < 8) put_byte($urandom_range(mpbs_pkg::ALPHABET, 255));
         else if (r < 11) push_word(rand_word(mpbs_pkg::CMD_RESTART));
         else put_byte(syms[$urandom_range(0, k - 1)]);
      end
   endtask

   initial begin
      int phase;
      tracker = new();
      calm = 0;
      quiet_cycles = 0;
      words_sent = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd = mpbs_pkg::CMD_WR_INFO;
      req_ch.node = '0;
      req_ch.symbol = '0;
      req_ch.goto_valid = 1'b0;
      req_ch.goto_target = '0;
      req_ch.fail_state = '0;
      req_ch.out_link_valid = 1'b0;
      req_ch.out_link = '0;
      req_ch.ends_pattern = 1'b0;
      req_ch.pattern_id = '0;
      req_ch.pattern_len = 5'd1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: root 0 -a-> 255 -a-> 1, node 1 links to 255 on output chain
      put_info(0, 0, 0, 0, 0, 0, 1);
      put_info(255, 0, 0, 0, 1, 15, 1);
      put_info(1, 255, 1, 255, 1, 0, 16);
      put_goto(0, 0, 1, 255);
      put_goto(0, 127, 0, 0);
      put_goto(255, 0, 1, 1);
      put_goto(255, 127, 0, 0);
      put_goto(1, 0, 0, 0);
      put_goto(1, 127, 0, 0);
      put_goto(0, 200, 1, 1);
      put_byte(0);
      put_byte(0);
      put_byte(0);
      put_byte(127);
      put_byte(255);
      put_byte(128);
      put_byte(0);
      push_word(rand_word(mpbs_pkg::CMD_RESTART));
      put_byte(0);
      put_byte(0);

      phase = 0;
      while (words_sent < RAND_WORDS - 30) begin
         calm = (phase == 2);
         if (phase == 3) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
            wait_drained();
         end
         run_phase();
         phase++;
      end
      calm = 0;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait_drained();
      repeat (DRAIN) @(posedge clock);
      while (tracker.pending_reports.size() != 0) begin
         void'(tracker.pending_reports.pop_front());
         tracker.report("expected report never arrived");
      end
      if (tracker.errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
